FILE: sv/bpc_pkg.sv
// Shared package of the barometric compensation core: field widths, datapath
// widths, scheme constants, the calibration register index codes and their struct.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bpc_pkg;

   // Channel field widths.
   localparam int RAW_W      = 24;
   localparam int COEF_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int PRESS_W    = 18;
   localparam int TEMP_OUT_W = 15;

   // Scheme shift amounts.
   localparam int REF_SHIFT       = 8;
   localparam int TEMP_SHIFT      = 23;
   localparam int OFF_SHIFT       = 7;
   localparam int SENS_SHIFT      = 8;
   localparam int T2_SHIFT        = 31;
   localparam int OFF_BASE_SHIFT  = 16;
   localparam int SENS_BASE_SHIFT = 15;
   localparam int PROD_SHIFT      = 21;
   localparam int PRESS_SHIFT     = 15;

   // Scheme temperature thresholds and output limits, in 0.01 degC.
   localparam int TEMP_REF     = 2000;
   localparam int TEMP_VLOW    = -1500;
   localparam int TEMP_OUT_MIN = -8192;
   localparam int TEMP_OUT_MAX = 16383;

   // Internal datapath widths, sized to the value ranges of each quantity.
   localparam int DT_W     = RAW_W + 1;                 // dT, signed
   localparam int TMUL_W   = 42;                        // dT times a coefficient
   localparam int DEV_W    = TMUL_W - TEMP_SHIFT;       // TEMP - 2000 and TEMP
   localparam int OFFP_W   = TMUL_W - OFF_SHIFT;        // C4*dT >> 7
   localparam int SENSP_W  = TMUL_W - SENS_SHIFT;       // C3*dT >> 8
   localparam int T2_W     = 17;                        // dT*dT >> 31
   localparam int DD_W     = T2_SHIFT + T2_W;           // dT*dT
   localparam int SQ_W     = 35;                        // squared deviations
   localparam int OFF2_W   = 38;
   localparam int SENS2_W  = 37;
   localparam int OFF_W    = OFF2_W + 1;                // final OFF, signed
   localparam int SENS_W   = SENS2_W + 1;               // final SENS, signed
   localparam int SPLIT_W  = 19;                        // low slice of SENS
   localparam int PP_W     = 44;                        // partial products
   localparam int PROD_W   = 62;                        // D1*SENS
   localparam int SCALED_W = PROD_W - PROD_SHIFT;
   localparam int DIFF_W   = SCALED_W + 1;
   localparam int PFULL_W  = DIFF_W - PRESS_SHIFT;

   localparam int NUM_STAGES = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS        = 3'd0,
      CSR_OFFSET      = 3'd1,
      CSR_SENS_TEMP   = 3'd2,
      CSR_OFFSET_TEMP = 3'd3,
      CSR_REF_TEMP    = 3'd4,
      CSR_TEMP_SLOPE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] sens;
      logic [COEF_W-1:0] offset;
      logic [COEF_W-1:0] sens_temp;
      logic [COEF_W-1:0] offset_temp;
      logic [COEF_W-1:0] ref_temp;
      logic [COEF_W-1:0] temp_slope;
   } coef_type;

endpackage

`default_nettype wire

FILE: sv/bpc_if.sv
// Valid/ready channel interfaces of the barometric compensation core:
// reading pairs in, compensated results out, and calibration register writes.
// Depends on bpc_pkg for the field widths.
`default_nettype none

interface bpc_req_if;
   import bpc_pkg::*;

   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_pressure;
   logic [RAW_W-1:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature,
                   input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature,
                   output ready);
endinterface

interface bpc_rsp_if;
   import bpc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic        [PRESS_W-1:0]    pressure_pa;
   logic signed [TEMP_OUT_W-1:0] temp_centideg;

   modport source (output valid, output pressure_pa, output temp_centideg,
                   input ready);
   modport sink   (input valid, input pressure_pa, input temp_centideg,
                   output ready);
endinterface

interface bpc_csr_if;
   import bpc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/bpc_csr_regs.sv
// Calibration register file of the barometric compensation core (C1 to C6).
// Depends on bpc_pkg and on bpc_csr_if from bpc_if.sv.
`default_nettype none

module bpc_csr_regs (
   input  wire logic              clock,
   input  wire logic              reset,
   bpc_csr_if.sink                csr_if,
   output bpc_pkg::coef_type      csr_coef
);
   import bpc_pkg::*;

   coef_type coef_ff;
   coef_type coef_in;

   // Writes are taken in every cycle outside reset; an index past the last
   // register is dropped.
   assign csr_if.ready = !reset;
   assign csr_coef     = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_SENS:        coef_in.sens        = csr_if.data;
            CSR_OFFSET:      coef_in.offset      = csr_if.data;
            CSR_SENS_TEMP:   coef_in.sens_temp   = csr_if.data;
            CSR_OFFSET_TEMP: coef_in.offset_temp = csr_if.data;
            CSR_REF_TEMP:    coef_in.ref_temp    = csr_if.data;
            CSR_TEMP_SLOPE:  coef_in.temp_slope  = csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/baro_pressure_temp_compensation_core.sv
// Top level of the barometric pressure and temperature compensation core.
// Depends on bpc_pkg, the channel interfaces in bpc_if.sv and bpc_csr_regs.
//
// Usage:
//   req_if carries one word per conversion pair: raw pressure D1 and raw
//   temperature D2, both 24-bit unsigned. rsp_if returns one word per request
//   word, in order: pressure in Pa (18-bit, saturated to 0..262143) and
//   temperature in 0.01 degC (15-bit two's complement, saturated to
//   -8192..16383), with the second-order low-temperature correction applied.
//   csr_if writes the six calibration words C1..C6 at indexes 0..5; an index
//   of six or seven is accepted and ignored. Calibration is expected to be
//   written only while no request word is in flight.
// Timing:
//   The datapath is a seven-stage pipeline whose last stage is the output
//   register on rsp_if. One word enters per cycle while rsp_if.ready is held
//   high. Stage depth is set by the 25x17-bit products of dT, the squared
//   temperature deviations and D1*SENS, split into a 25x19-bit and a
//   24x19-bit partial product.
// Reset and stall:
//   Synchronous reset empties the pipeline, clears C1..C6 and holds both
//   ready outputs low. A stage holds its word while the next one is full and
//   stalled, so a stalled receiver fills empty stages before it pushes back
//   on req_if.ready; nothing is dropped or repeated.
`default_nettype none

module baro_pressure_temp_compensation_core (
   input  wire logic clock,
   input  wire logic reset,
   bpc_req_if.sink   req_if,
   bpc_rsp_if.source rsp_if,
   bpc_csr_if.sink   csr_if
);
   import bpc_pkg::*;

   // Derived constants on the temperature deviation d = TEMP - 2000.
   localparam logic signed [DEV_W-1:0] DEV_REF      = DEV_W'(TEMP_REF);
   localparam logic signed [DEV_W-1:0] DEV_VLOW_OFS = DEV_W'(TEMP_REF - TEMP_VLOW);
   localparam logic signed [DEV_W-1:0] DEV_VLOW     = DEV_W'(TEMP_VLOW - TEMP_REF);
   localparam logic signed [DEV_W-1:0] DEV_OUT_MIN  = DEV_W'(TEMP_OUT_MIN);
   localparam logic signed [DEV_W-1:0] DEV_OUT_MAX  = DEV_W'(TEMP_OUT_MAX);

   coef_type coef;

   bpc_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .csr_if   (csr_if),
      .csr_coef (coef)
   );

   // ---------------------------------------------------------------------
   // Pipeline control. A stage may load when it is empty or when the stage
   // after it moves on in the same cycle; the last stage is the output
   // register and moves when the receiver takes the word.
   // ---------------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] adv;

   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_if.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? req_if.valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // No word is taken while reset is held, since it would be dropped.
   assign req_if.ready = adv[0] && !reset;

   // ---------------------------------------------------------------------
   // Stage 1: dT = D2 - C5*256.
   // ---------------------------------------------------------------------
   logic signed [DT_W-1:0]  s1_dt_in;
   logic signed [DT_W-1:0]  s1_dt_ff;
   logic        [RAW_W-1:0] s1_d1_ff;

   assign s1_dt_in = signed'({1'b0, req_if.raw_temperature})
                   - signed'({1'b0, coef.ref_temp, REF_SHIFT'(0)});

   // ---------------------------------------------------------------------
   // Stage 2: the four products of dT. The scaled terms are kept as their
   // upper slices, which is the floor shift of the scheme.
   // ---------------------------------------------------------------------
   logic signed [TMUL_W-1:0]  tprod;
   logic signed [TMUL_W-1:0]  oprod;
   logic signed [TMUL_W-1:0]  sprod;
   logic        [DD_W-1:0]    dd;
   logic signed [DEV_W-1:0]   s2_dev_in;
   logic signed [OFFP_W-1:0]  s2_offp_in;
   logic signed [SENSP_W-1:0] s2_sensp_in;
   logic        [T2_W-1:0]    s2_t2_in;
   logic signed [DEV_W-1:0]   s2_dev_ff;
   logic signed [OFFP_W-1:0]  s2_offp_ff;
   logic signed [SENSP_W-1:0] s2_sensp_ff;
   logic        [T2_W-1:0]    s2_t2_ff;
   logic        [RAW_W-1:0]   s2_d1_ff;

   assign tprod = s1_dt_ff * signed'({1'b0, coef.temp_slope});
   assign oprod = s1_dt_ff * signed'({1'b0, coef.offset_temp});
   assign sprod = s1_dt_ff * signed'({1'b0, coef.sens_temp});
   assign dd    = s1_dt_ff * s1_dt_ff;

   assign s2_dev_in   = tprod[TMUL_W-1:TEMP_SHIFT];
   assign s2_offp_in  = oprod[TMUL_W-1:OFF_SHIFT];
   assign s2_sensp_in = sprod[TMUL_W-1:SENS_SHIFT];
   assign s2_t2_in    = dd[DD_W-1:T2_SHIFT];

   // ---------------------------------------------------------------------
   // Stage 3: first-order TEMP, OFF and SENS, the two squared deviations
   // used by the low-temperature correction, and the two range flags.
   // ---------------------------------------------------------------------
   logic signed [DEV_W-1:0]   vdev;
   logic        [SQ_W-1:0]    s3_dsq_in;
   logic        [SQ_W-1:0]    s3_esq_in;
   logic signed [DEV_W-1:0]   s3_temp_in;
   logic signed [OFFP_W-1:0]  s3_off_in;
   logic signed [SENSP_W-1:0] s3_sens_in;
   logic                      s3_low_in;
   logic                      s3_vlow_in;
   logic        [SQ_W-1:0]    s3_dsq_ff;
   logic        [SQ_W-1:0]    s3_esq_ff;
   logic signed [DEV_W-1:0]   s3_temp_ff;
   logic signed [OFFP_W-1:0]  s3_off_ff;
   logic signed [SENSP_W-1:0] s3_sens_ff;
   logic                      s3_low_ff;
   logic                      s3_vlow_ff;
   logic        [T2_W-1:0]    s3_t2_ff;
   logic        [RAW_W-1:0]   s3_d1_ff;

   // vdev is TEMP + 1500; its square only matters below -15 degC.
   assign vdev       = s2_dev_ff + DEV_VLOW_OFS;
   assign s3_dsq_in  = s2_dev_ff * s2_dev_ff;
   assign s3_esq_in  = vdev * vdev;
   assign s3_temp_in = s2_dev_ff + DEV_REF;
   assign s3_low_in  = s2_dev_ff[DEV_W-1];
   assign s3_vlow_in = s2_dev_ff < DEV_VLOW;
   assign s3_off_in  = signed'({3'b000, coef.offset, OFF_BASE_SHIFT'(0)}) + s2_offp_ff;
   assign s3_sens_in = signed'({3'b000, coef.sens, SENS_BASE_SHIFT'(0)}) + s2_sensp_ff;

   // ---------------------------------------------------------------------
   // Stage 4: second-order correction and temperature saturation. The
   // constant factors 5, 7 and 11 are shift-and-add terms, 7 as a shift less one.
   // ---------------------------------------------------------------------
   logic        [SQ_W+1:0]       sq5;
   logic        [SQ_W+2:0]       esq7;
   logic        [SQ_W+3:0]       esq11;
   logic        [OFF2_W-1:0]     off2;
   logic        [SENS2_W-1:0]    sens2;
   logic signed [DEV_W-1:0]      temp_full;
   logic signed [OFF_W-1:0]      s4_off_in;
   logic signed [SENS_W-1:0]     s4_sens_in;
   logic signed [TEMP_OUT_W-1:0] s4_temp_in;
   logic signed [OFF_W-1:0]      s4_off_ff;
   logic signed [SENS_W-1:0]     s4_sens_ff;
   logic signed [TEMP_OUT_W-1:0] s4_temp_ff;
   logic        [RAW_W-1:0]      s4_d1_ff;

   always_comb begin
      sq5   = ((SQ_W+2)'(s3_dsq_ff) << 2) + (SQ_W+2)'(s3_dsq_ff);
      esq7  = ((SQ_W+3)'(s3_esq_ff) << 3) - (SQ_W+3)'(s3_esq_ff);
      esq11 = ((SQ_W+4)'(s3_esq_ff) << 3) + ((SQ_W+4)'(s3_esq_ff) << 1)
            + (SQ_W+4)'(s3_esq_ff);

      off2  = '0;
      sens2 = '0;
      if (s3_low_ff) begin
         off2  = OFF2_W'(sq5 >> 1);
         sens2 = SENS2_W'(sq5 >> 2);
         if (s3_vlow_ff) begin
            off2  = off2 + OFF2_W'(esq7);
            sens2 = sens2 + SENS2_W'(esq11 >> 1);
         end
      end

      s4_off_in  = OFF_W'(s3_off_ff) - signed'({1'b0, off2});
      s4_sens_in = SENS_W'(s3_sens_ff) - signed'({1'b0, sens2});

      // Below 20 degC the temperature also loses dT*dT >> 31.
      if (s3_low_ff) begin
         temp_full = s3_temp_ff - signed'({2'b00, s3_t2_ff});
      end else begin
         temp_full = s3_temp_ff;
      end

      priority if (temp_full < DEV_OUT_MIN) begin
         s4_temp_in = TEMP_OUT_W'(DEV_OUT_MIN);
      end else if (temp_full > DEV_OUT_MAX) begin
         s4_temp_in = TEMP_OUT_W'(DEV_OUT_MAX);
      end else begin
         s4_temp_in = TEMP_OUT_W'(temp_full);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: D1*SENS as two partial products over the signed upper and the
   // unsigned lower slice of SENS.
   // ---------------------------------------------------------------------
   logic signed [PP_W-1:0]       s5_pphi_in;
   logic        [PP_W-1:0]       s5_pplo_in;
   logic signed [PP_W-1:0]       s5_pphi_ff;
   logic        [PP_W-1:0]       s5_pplo_ff;
   logic signed [OFF_W-1:0]      s5_off_ff;
   logic signed [TEMP_OUT_W-1:0] s5_temp_ff;

   assign s5_pphi_in = signed'({1'b0, s4_d1_ff}) * signed'(s4_sens_ff[SENS_W-1:SPLIT_W]);
   assign s5_pplo_in = s4_d1_ff * s4_sens_ff[SPLIT_W-1:0];

   // ---------------------------------------------------------------------
   // Stage 6: recombine the product and scale it down by 2^21.
   // ---------------------------------------------------------------------
   logic signed [PROD_W-1:0]     prod;
   logic signed [SCALED_W-1:0]   s6_scaled_in;
   logic signed [SCALED_W-1:0]   s6_scaled_ff;
   logic signed [OFF_W-1:0]      s6_off_ff;
   logic signed [TEMP_OUT_W-1:0] s6_temp_ff;

   assign prod         = (PROD_W'(s5_pphi_ff) <<< SPLIT_W) + signed'(PROD_W'(s5_pplo_ff));
   assign s6_scaled_in = prod[PROD_W-1:PROD_SHIFT];

   // ---------------------------------------------------------------------
   // Stage 7 (output register): subtract OFF, scale by 2^15, saturate.
   // ---------------------------------------------------------------------
   logic signed [DIFF_W-1:0]     diff;
   logic signed [PFULL_W-1:0]    press_full;
   logic        [PRESS_W-1:0]    s7_press_in;
   logic        [PRESS_W-1:0]    s7_press_ff;
   logic signed [TEMP_OUT_W-1:0] s7_temp_ff;

   always_comb begin
      diff       = DIFF_W'(s6_scaled_ff) - DIFF_W'(s6_off_ff);
      press_full = diff[DIFF_W-1:PRESS_SHIFT];
      priority if (press_full[PFULL_W-1]) begin
         s7_press_in = '0;
      end else if (press_full[PFULL_W-2:PRESS_W] != '0) begin
         s7_press_in = '1;
      end else begin
         s7_press_in = press_full[PRESS_W-1:0];
      end
   end

   // Payload registers: each stage loads whenever it is allowed to advance.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_dt_ff <= s1_dt_in;
         s1_d1_ff <= req_if.raw_pressure;
      end
      if (adv[1]) begin
         s2_dev_ff   <= s2_dev_in;
         s2_offp_ff  <= s2_offp_in;
         s2_sensp_ff <= s2_sensp_in;
         s2_t2_ff    <= s2_t2_in;
         s2_d1_ff    <= s1_d1_ff;
      end
      if (adv[2]) begin
         s3_dsq_ff  <= s3_dsq_in;
         s3_esq_ff  <= s3_esq_in;
         s3_temp_ff <= s3_temp_in;
         s3_off_ff  <= s3_off_in;
         s3_sens_ff <= s3_sens_in;
         s3_low_ff  <= s3_low_in;
         s3_vlow_ff <= s3_vlow_in;
         s3_t2_ff   <= s2_t2_ff;
         s3_d1_ff   <= s2_d1_ff;
      end
      if (adv[3]) begin
         s4_off_ff  <= s4_off_in;
         s4_sens_ff <= s4_sens_in;
         s4_temp_ff <= s4_temp_in;
         s4_d1_ff   <= s3_d1_ff;
      end
      if (adv[4]) begin
         s5_pphi_ff <= s5_pphi_in;
         s5_pplo_ff <= s5_pplo_in;
         s5_off_ff  <= s4_off_ff;
         s5_temp_ff <= s4_temp_ff;
      end
      if (adv[5]) begin
         s6_scaled_ff <= s6_scaled_in;
         s6_off_ff    <= s5_off_ff;
         s6_temp_ff   <= s5_temp_ff;
      end
      if (adv[6]) begin
         s7_press_ff <= s7_press_in;
         s7_temp_ff  <= s6_temp_ff;
      end
   end

   assign rsp_if.valid         = vld_ff[NUM_STAGES-1];
   assign rsp_if.pressure_pa   = s7_press_ff;
   assign rsp_if.temp_centideg = s7_temp_ff;

endmodule

`default_nettype wire
